/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used across the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/tbc_pkg.sv */
// ---------------------------------------------------------------------------
// Tempo beat clock package
// Widths, constants, register indexes and shared types of the beat clock.
// ---------------------------------------------------------------------------
package tbc_pkg;

   // Field widths
   localparam int TIME_W   = 32;
   localparam int BPM_W    = 17;
   localparam int BPB_W    = 8;
   localparam int COUNT_W  = 32;
   localparam int HIT_W    = 4;
   localparam int FRAC_W   = 16;

   // Arithmetic widths: the product is below 2^49, padded to an even width
   // so that the divider can take two bits per cycle.
   localparam int PROD_W   = TIME_W + BPM_W;
   localparam int WORK_W   = PROD_W + 1;
   localparam int POS_W    = 48;
   localparam int REM_W    = 13;

   localparam logic [REM_W:0] BPM_DIVISOR = 14'd6000;

   // Step counts of the serial engine
   localparam int MUL_STEPS = BPM_W;
   localparam int DIV_STEPS = WORK_W / 2;
   // After this division step only the sixteen fraction bits remain.
   localparam int BEAT_STEP = DIV_STEPS - FRAC_W / 2 - 1;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Defaults and reset values
   localparam logic [BPM_W-1:0] DEFAULT_BPM = 17'd12000;
   localparam logic [BPB_W-1:0] DEFAULT_BPB = 8'd4;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = BPM_W;
   localparam logic [CSR_IDX_W-1:0] CSR_BPM_X100      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BEATS_PER_BAR = 2'd1;

   // Output tdata layout
   localparam int RSP_FIELDS_W = 4 * COUNT_W + HIT_W + BPB_W + 4 * FRAC_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef struct packed {
      logic idle;
      logic done;
   } eng_status_type;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] quo;
      logic [BPB_W-1:0] beat;
   } eng_result_type;

endpackage

/* rtl/tbc_engine.sv */
// ---------------------------------------------------------------------------
// Tempo beat clock serial engine
// Bit-serial multiply of time by tempo, then a two-bit-per-cycle division by
// 6000 whose quotient bits feed a second divider by beats per bar directly.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tbc_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [tbc_pkg::TIME_W-1:0]     audio_time,
   input  logic [tbc_pkg::BPM_W-1:0]      bpm,
   input  logic [tbc_pkg::BPB_W-1:0]      bpb,
   input  logic                           take,
   output tbc_pkg::eng_status_type        status,
   output tbc_pkg::eng_result_type        result
);
   import tbc_pkg::*;

   typedef enum logic [1:0] {E_IDLE, E_MUL, E_DIV, E_DONE} state_type;

   state_type          state_ff;
   logic [STEP_W-1:0]  cnt_ff;
   logic [TIME_W-1:0]  time_ff;
   logic [WORK_W-1:0]  work_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [BPB_W-1:0]   brem_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   quo_ff;
   logic [BPB_W-1:0]   beat_ff;

   logic [TIME_W:0]    msum;
   logic [REM_W:0]     r1, r1n, r2, r2n;
   logic               q1, q0;
   logic [BPB_W:0]     s1, s1n, s2, s2n;
   logic               d1, d0;

   // Shift-and-add step: the low bit of the tempo decides whether time is added.
   always_comb begin
      msum = {1'b0, work_ff[PROD_W-1:BPM_W]} + (work_ff[0] ? {1'b0, time_ff} : '0);
   end

   // Two restoring steps by 6000, each quotient bit passed straight on to the
   // divider by beats per bar, which thus divides the beat position itself.
   always_comb begin
      r1  = {rem_ff, work_ff[WORK_W-1]};
      q1  = (r1 >= BPM_DIVISOR);
      r1n = q1 ? (r1 - BPM_DIVISOR) : r1;
      r2  = {r1n[REM_W-1:0], work_ff[WORK_W-2]};
      q0  = (r2 >= BPM_DIVISOR);
      r2n = q0 ? (r2 - BPM_DIVISOR) : r2;

      s1  = {brem_ff, q1};
      d1  = (s1 >= {1'b0, bpb});
      s1n = d1 ? (s1 - {1'b0, bpb}) : s1;
      s2  = {s1n[BPB_W-1:0], q0};
      d0  = (s2 >= {1'b0, bpb});
      s2n = d0 ? (s2 - {1'b0, bpb}) : s2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            E_IDLE: begin
               if (start) begin
                  time_ff  <= audio_time;
                  work_ff  <= {{(WORK_W - BPM_W){1'b0}}, bpm};
                  rem_ff   <= '0;
                  brem_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= E_MUL;
               end
            end
            E_MUL: begin
               work_ff <= {1'b0, msum, work_ff[BPM_W-1:1]};
               if (cnt_ff == STEP_W'(MUL_STEPS - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= E_DIV;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            E_DIV: begin
               work_ff <= {work_ff[WORK_W-3:0], 2'b00};
               rem_ff  <= r2n[REM_W-1:0];
               brem_ff <= s2n[BPB_W-1:0];
               pos_ff  <= {pos_ff[POS_W-3:0], q1, q0};
               quo_ff  <= {quo_ff[POS_W-3:0], d1, d0};
               if (cnt_ff == STEP_W'(BEAT_STEP)) begin
                  beat_ff <= s2n[BPB_W-1:0];
               end
               if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= E_DONE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            E_DONE: begin
               if (take) begin
                  state_ff <= E_IDLE;
               end
            end
            default: begin
               state_ff <= E_IDLE;
            end
         endcase
      end
   end

   assign status.idle = (state_ff == E_IDLE);
   assign status.done = (state_ff == E_DONE);
   assign result.pos  = pos_ff;
   assign result.quo  = quo_ff;
   assign result.beat = beat_ff;

   `ASSERT_IMPLIES(a_rem_below_divisor, clock, reset, state_ff == E_DIV, {1'b0, rem_ff} < BPM_DIVISOR, "division remainder out of range")
   `ASSERT_IMPLIES(a_mul_count_range, clock, reset, state_ff == E_MUL, cnt_ff < STEP_W'(MUL_STEPS), "multiply step count out of range")
   `ASSERT_NEXT(a_done_until_taken, clock, reset, state_ff == E_DONE && !take, state_ff == E_DONE, "finished result lost before transfer")

endmodule

/* rtl/tempo_beat_clock_core.sv */
// ---------------------------------------------------------------------------
// Tempo beat clock core
// Turns audio time into musical counts, hit flags, bar progress and phases.
// ---------------------------------------------------------------------------
//  Channel  Direction  Carries
//  req_     in         audio_time (Q16.16 seconds)
//  rsp_     out        counts, hit_mask, beat_in_bar, bar_progress, phases
//  csr_     in         bpm_x100 (index 0), beats_per_bar (index 1)
//
// Each item passes through idle, the bit-serial multiply, the two-bit-per-cycle
// division chain and a done state that hands the result to the output register
// once that register is free or being emptied; req_tready is high only in idle.
// A result waiting in the output register does not stop the next input; only
// a second finished result waits until the first has been taken.
// Reset is synchronous and restores the default tempo, bar length and counts.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tempo_beat_clock_core (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: audio_time[31:0]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tbc_pkg::TIME_W-1:0]          req_tdata,
   // rsp_tdata: quarter_count[31:0], eighth_count[63:32], sixteenth_count[95:64],
   //   bar_count[127:96], hit_mask[131:128], beat_in_bar[139:132],
   //   bar_progress[155:140], quarter_phase[171:156], eighth_phase[187:172],
   //   sixteenth_phase[203:188], zero fill[207:204]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tbc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [tbc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tbc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tbc_pkg::*;

   logic [BPM_W-1:0]    bpm_ff;
   logic [BPB_W-1:0]    bpb_ff;
   logic [BPM_W-1:0]    bpm_eff;
   logic [BPB_W-1:0]    bpb_eff;

   eng_status_type      eng_status;
   eng_result_type      eng_result;
   logic                eng_start;
   logic                eng_take;

   logic                rsp_valid_ff;
   logic [COUNT_W-1:0]  last_quarter_ff;
   logic [COUNT_W-1:0]  last_eighth_ff;
   logic [COUNT_W-1:0]  last_sixteenth_ff;
   logic [COUNT_W-1:0]  last_bar_ff;
   logic [HIT_W-1:0]    hit_ff;
   logic [BPB_W-1:0]    beat_ff;
   logic [FRAC_W-1:0]   prog_ff;
   logic [FRAC_W-1:0]   qphase_ff;
   logic [FRAC_W-1:0]   ephase_ff;
   logic [FRAC_W-1:0]   sphase_ff;

   logic [COUNT_W-1:0]  quarter;
   logic [COUNT_W-1:0]  eighth;
   logic [COUNT_W-1:0]  sixteenth;
   logic [COUNT_W-1:0]  bar;

   // Configuration registers; writes to other indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         bpm_ff <= DEFAULT_BPM;
         bpb_ff <= DEFAULT_BPB;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BPM_X100: begin
               bpm_ff <= csr_wdata;
            end
            CSR_BEATS_PER_BAR: begin
               bpb_ff <= csr_wdata[BPB_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign bpm_eff = (bpm_ff == '0) ? DEFAULT_BPM : bpm_ff;
   assign bpb_eff = (bpb_ff == '0) ? DEFAULT_BPB : bpb_ff;

   assign req_tready = eng_status.idle;
   assign eng_start  = req_tvalid && eng_status.idle;
   assign eng_take   = eng_status.done && (!rsp_valid_ff || rsp_tready);

   tbc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (eng_start),
      .audio_time (req_tdata),
      .bpm        (bpm_eff),
      .bpb        (bpb_eff),
      .take       (eng_take),
      .status     (eng_status),
      .result     (eng_result)
   );

   // The beat position's integer part starts at bit 16; the bar quotient of
   // the whole position has the bar count above the progress fraction.
   assign quarter   = eng_result.pos[POS_W-1:FRAC_W];
   assign eighth    = eng_result.pos[POS_W-2:FRAC_W-1];
   assign sixteenth = eng_result.pos[POS_W-3:FRAC_W-2];
   assign bar       = eng_result.quo[POS_W-1:FRAC_W];

   // The count registers double as the previous-item state for the hit mask.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff      <= 1'b0;
         last_quarter_ff   <= '0;
         last_eighth_ff    <= '0;
         last_sixteenth_ff <= '0;
         last_bar_ff       <= '0;
      end else begin
         if (eng_take) begin
            rsp_valid_ff      <= 1'b1;
            last_quarter_ff   <= quarter;
            last_eighth_ff    <= eighth;
            last_sixteenth_ff <= sixteenth;
            last_bar_ff       <= bar;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (eng_take) begin
         hit_ff    <= {bar != last_bar_ff, sixteenth != last_sixteenth_ff,
                       eighth != last_eighth_ff, quarter != last_quarter_ff};
         beat_ff   <= eng_result.beat;
         prog_ff   <= eng_result.quo[FRAC_W-1:0];
         qphase_ff <= eng_result.pos[FRAC_W-1:0];
         ephase_ff <= {eng_result.pos[FRAC_W-2:0], 1'b0};
         sphase_ff <= {eng_result.pos[FRAC_W-3:0], 2'b00};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}}, sphase_ff, ephase_ff, qphase_ff,
                        prog_ff, beat_ff, hit_ff, last_bar_ff, last_sixteenth_ff,
                        last_eighth_ff, last_quarter_ff};

   `ASSERT_IMPLIES(a_hit_nesting, clock, reset, rsp_valid_ff, (!hit_ff[0] || hit_ff[1]) && (!hit_ff[1] || hit_ff[2]), "finer count unchanged while coarser count changed")
   `ASSERT_NEXT(a_take_gives_valid, clock, reset, eng_take, rsp_valid_ff, "result taken from engine but not presented")
   `ASSERT_NEXT(a_result_waits, clock, reset, eng_status.done && rsp_valid_ff && !rsp_tready, eng_status.done, "finished result dropped while output stalled")

endmodule
